FILE: rtl/fbpa_pkg.sv
// Package for the fixed block pool allocator: types, codes and the microcode table.
`default_nettype none

package fbpa_pkg;

  localparam int unsigned POOL_BLOCKS_DEF = 32;
  // Widest block number a legal pool can hold (pool size at most 256).
  localparam int unsigned BLK_WIDE_W      = 8;
  localparam int unsigned BLK_IN_W        = 6;
  localparam int unsigned GRANT_W         = 5;
  localparam int unsigned COUNT_OUT_W     = 6;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned IN_TDATA_W      = 8;
  localparam int unsigned OUT_TDATA_W     = 16;
  localparam int unsigned UPC_W           = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_RANGE  = 2'd2,
    ST_DOUBLE = 2'd3
  } status_e;

  // Stall conditions: the step holds while its condition is true.
  typedef enum logic [1:0] {
    W_NONE = 2'd0,
    W_IN   = 2'd1,
    W_OUT  = 2'd2,
    W_SCAN = 2'd3
  } wait_sel_e;

  // Branch conditions: jump to target when true, else fall through.
  typedef enum logic [2:0] {
    B_NEVER  = 3'd0,
    B_ALWAYS = 3'd1,
    B_FREE   = 3'd2,
    B_EMPTY  = 3'd3,
    B_RANGE  = 3'd4,
    B_FULL   = 3'd5,
    B_HIT    = 3'd6
  } br_sel_e;

  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t S_IDLE   = 4'd0;
  localparam upc_t S_DISP   = 4'd1;
  localparam upc_t S_ACHK   = 4'd2;
  localparam upc_t S_ATAKE  = 4'd3;
  localparam upc_t S_AEMPTY = 4'd4;
  localparam upc_t S_FCHK   = 4'd5;
  localparam upc_t S_FFULL  = 4'd6;
  localparam upc_t S_FSCAN  = 4'd7;
  localparam upc_t S_FAPP   = 4'd8;
  localparam upc_t S_FRANGE = 4'd9;
  localparam upc_t S_FDBL   = 4'd10;
  localparam upc_t S_OUT    = 4'd11;

  typedef struct packed {
    wait_sel_e wait_sel;
    br_sel_e   br_sel;
    upc_t      target;
    logic      in_rdy;
    logic      rd_take;
    logic      scan_init;
    logic      scan_run;
    logic      alloc_commit;
    logic      free_commit;
    logic      res_ld;
    status_e   res_status;
    logic      out_ld;
  } ctl_word_t;

  function automatic ctl_word_t ucode_rom(input upc_t step);
    ctl_word_t w;
    w = '{wait_sel: W_NONE, br_sel: B_NEVER, target: S_IDLE, in_rdy: 1'b0,
          rd_take: 1'b0, scan_init: 1'b0, scan_run: 1'b0, alloc_commit: 1'b0,
          free_commit: 1'b0, res_ld: 1'b0, res_status: ST_OK, out_ld: 1'b0};
    case (step)
      S_IDLE: begin
        w.wait_sel = W_IN;
        w.in_rdy   = 1'b1;
      end
      S_DISP: begin
        w.br_sel = B_FREE;
        w.target = S_FCHK;
      end
      S_ACHK: begin
        w.br_sel  = B_EMPTY;
        w.target  = S_AEMPTY;
        w.rd_take = 1'b1;
      end
      S_ATAKE: begin
        w.alloc_commit = 1'b1;
        w.res_ld       = 1'b1;
        w.res_status   = ST_OK;
        w.br_sel       = B_ALWAYS;
        w.target       = S_OUT;
      end
      S_AEMPTY: begin
        w.res_ld     = 1'b1;
        w.res_status = ST_EMPTY;
        w.br_sel     = B_ALWAYS;
        w.target     = S_OUT;
      end
      S_FCHK: begin
        w.br_sel    = B_RANGE;
        w.target    = S_FRANGE;
        w.scan_init = 1'b1;
      end
      S_FFULL: begin
        w.br_sel = B_FULL;
        w.target = S_FDBL;
      end
      S_FSCAN: begin
        w.wait_sel = W_SCAN;
        w.scan_run = 1'b1;
        w.br_sel   = B_HIT;
        w.target   = S_FDBL;
      end
      S_FAPP: begin
        w.free_commit = 1'b1;
        w.res_ld      = 1'b1;
        w.res_status  = ST_OK;
        w.br_sel      = B_ALWAYS;
        w.target      = S_OUT;
      end
      S_FRANGE: begin
        w.res_ld     = 1'b1;
        w.res_status = ST_RANGE;
        w.br_sel     = B_ALWAYS;
        w.target     = S_OUT;
      end
      S_FDBL: begin
        w.res_ld     = 1'b1;
        w.res_status = ST_DOUBLE;
        w.br_sel     = B_ALWAYS;
        w.target     = S_OUT;
      end
      S_OUT: begin
        w.wait_sel = W_OUT;
        w.out_ld   = 1'b1;
        w.br_sel   = B_ALWAYS;
        w.target   = S_IDLE;
      end
      default: begin
        w.br_sel = B_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator: microcoded sequencer over a circular free list.
// Allocate: accept, dispatch, check and read the ring, take, output. Free: accept,
// dispatch, range check, full check, scan of the free entries (one ring read per cycle,
// ends early on a hit), append, output. Throughput: one transaction in flight; the next
// is taken once the output register is loaded; an unaccepted result stalls the load.
// Reset: ring reads back block i at entry i, free count = POOL_BLOCKS, pointers zero.
`default_nettype none

module fixed_block_pool_allocator #(
  parameter int unsigned POOL_BLOCKS = fbpa_pkg::POOL_BLOCKS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire logic [fbpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,  // [5:0] block_index
  input  wire logic                             s_axis_tuser_i,  // [0] operation
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  output logic [fbpa_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,  // [4:0] granted_block,
                                                                 // [10:5] free_count
  output logic [fbpa_pkg::STATUS_W-1:0]         m_axis_tuser_o   // [1:0] status
);
  import fbpa_pkg::*;

  localparam int unsigned AW = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(POOL_BLOCKS + 1);

  typedef logic [AW-1:0] ptr_t;
  typedef logic [CW-1:0] cnt_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    return (p == AW'(POOL_BLOCKS - 1)) ? '0 : p + 1'b1;
  endfunction

  // sequencer
  upc_t      upc_q, upc_d;
  ctl_word_t ctl;
  logic      wait_act;
  logic      br_take;
  logic      go;

  // datapath
  logic                op_q;
  logic [BLK_IN_W-1:0] blk_q;
  ptr_t                take_ptr_q, take_ptr_d;
  ptr_t                ret_ptr_q, ret_ptr_d;
  cnt_t                free_cnt_q, free_cnt_d;
  ptr_t                scan_pos_q, scan_pos_d;
  cnt_t                scan_left_q, scan_left_d;
  logic                rd_vld_q, rd_vld_d;
  logic                scan_busy;
  logic                hit;
  logic                range_bad;
  logic                pool_full;

  // ring memory with per-entry written flags; unwritten entries read as their index
  ptr_t                ring_mem [POOL_BLOCKS];
  logic [POOL_BLOCKS-1:0] ent_vld_q;
  logic                rd_en;
  ptr_t                rd_addr;
  ptr_t                rd_raw_q;
  ptr_t                rd_addr_q;
  logic                rd_dflt_q;
  ptr_t                rd_data;

  // result
  status_e             res_status_q;
  logic [GRANT_W-1:0]  grant_q;
  logic                out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  status_e             out_user_q;

  assign ctl = ucode_rom(upc_q);

  assign rd_data   = rd_dflt_q ? rd_addr_q : rd_raw_q;
  assign hit       = rd_vld_q && (BLK_WIDE_W'(rd_data) == BLK_WIDE_W'(blk_q));
  assign scan_busy = (scan_left_q != '0) || rd_vld_q;
  assign range_bad = (32'(blk_q) >= POOL_BLOCKS);
  assign pool_full = (free_cnt_q == CW'(POOL_BLOCKS));

  always_comb begin
    case (ctl.wait_sel)
      W_NONE:  wait_act = 1'b0;
      W_IN:    wait_act = !s_axis_tvalid_i;
      W_OUT:   wait_act = out_vld_q && !m_axis_tready_i;
      W_SCAN:  wait_act = scan_busy && !hit;
      default: wait_act = 1'b0;
    endcase
  end

  always_comb begin
    case (ctl.br_sel)
      B_NEVER:  br_take = 1'b0;
      B_ALWAYS: br_take = 1'b1;
      B_FREE:   br_take = op_q;
      B_EMPTY:  br_take = (free_cnt_q == '0);
      B_RANGE:  br_take = range_bad;
      B_FULL:   br_take = pool_full;
      B_HIT:    br_take = hit;
      default:  br_take = 1'b0;
    endcase
  end

  assign go = !wait_act;

  // next step
  always_comb begin
    if (wait_act) begin
      upc_d = upc_q;
    end else if (br_take) begin
      upc_d = ctl.target;
    end else begin
      upc_d = upc_q + 1'b1;
    end
  end

  // pointer, count and scan updates
  always_comb begin
    take_ptr_d  = take_ptr_q;
    ret_ptr_d   = ret_ptr_q;
    free_cnt_d  = free_cnt_q;
    scan_pos_d  = scan_pos_q;
    scan_left_d = scan_left_q;
    rd_vld_d    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = take_ptr_q;
    if (ctl.rd_take) begin
      rd_en = 1'b1;
    end
    if (ctl.scan_init) begin
      scan_pos_d  = take_ptr_q;
      scan_left_d = free_cnt_q;
    end
    if (ctl.scan_run && (scan_left_q != '0)) begin
      rd_en       = 1'b1;
      rd_addr     = scan_pos_q;
      rd_vld_d    = 1'b1;
      scan_pos_d  = ptr_next(scan_pos_q);
      scan_left_d = scan_left_q - 1'b1;
    end
    if (go && ctl.alloc_commit) begin
      take_ptr_d = ptr_next(take_ptr_q);
      free_cnt_d = free_cnt_q - 1'b1;
    end
    if (go && ctl.free_commit) begin
      ret_ptr_d  = ptr_next(ret_ptr_q);
      free_cnt_d = free_cnt_q + 1'b1;
    end
  end

  assign s_axis_tready_o = ctl.in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= S_IDLE;
      take_ptr_q  <= '0;
      ret_ptr_q   <= '0;
      free_cnt_q  <= CW'(POOL_BLOCKS);
      scan_pos_q  <= '0;
      scan_left_q <= '0;
      rd_vld_q    <= 1'b0;
      ent_vld_q   <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      take_ptr_q  <= take_ptr_d;
      ret_ptr_q   <= ret_ptr_d;
      free_cnt_q  <= free_cnt_d;
      scan_pos_q  <= scan_pos_d;
      scan_left_q <= scan_left_d;
      rd_vld_q    <= rd_vld_d;
      if (go && ctl.free_commit) begin
        ent_vld_q[ret_ptr_q] <= 1'b1;
      end
      if (go && ctl.out_ld) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (go && ctl.free_commit) begin
      ring_mem[ret_ptr_q] <= AW'(blk_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_raw_q  <= ring_mem[rd_addr];
      rd_dflt_q <= !ent_vld_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl.in_rdy && s_axis_tvalid_i) begin
      op_q  <= s_axis_tuser_i;
      blk_q <= s_axis_tdata_i[BLK_IN_W-1:0];
    end
    if (go && ctl.res_ld) begin
      res_status_q <= ctl.res_status;
      grant_q      <= ctl.alloc_commit ? GRANT_W'(BLK_WIDE_W'(rd_data)) : '0;
    end
    if (go && ctl.out_ld) begin
      out_user_q <= res_status_q;
      out_data_q <= OUT_TDATA_W'({COUNT_OUT_W'(free_cnt_q), grant_q});
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= CW'(POOL_BLOCKS))
    else $error("free count above pool size");

  // scan_left_q may keep a stale value after an early hit; only checked while scanning
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == S_FSCAN) |-> (scan_left_q <= free_cnt_q))
    else $error("scan runs past valid free entries");

  a_alloc_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.alloc_commit && go) |=> (free_cnt_q == $past(free_cnt_q) - 1'b1))
    else $error("allocate did not drop free count");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> ($past(upc_q) == S_OUT))
    else $error("result loaded outside output step");
`endif

endmodule

`default_nettype wire
